// ===== hw/rtl/efsd_pkg.sv =====
// package: shared types, widths and codes for the earliest-free server dispatch
`default_nettype none
package efsd_pkg;

    localparam int NUM_SERVERS_DEF = 64;
    localparam int TIME_W          = 32;
    localparam int DUR_W           = 16;
    localparam int ACT_W           = 7;
    localparam int OUT_IDX_W       = 6;

    localparam logic [ACT_W-1:0] ACTIVE_RESET = 7'd64;

    // item kinds carried on s_tuser
    localparam logic OP_ASSIGN = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_WAIT
    } efsd_state_t;

    // scan token handed from cell to cell (indices travel beside it)
    typedef struct packed {
        logic              v;
        logic              run_v;
        logic [TIME_W-1:0] best_t;
        logic [TIME_W-1:0] run_t;
    } efsd_tok_t;

    // broadcast command to every cell
    typedef struct packed {
        logic              clr;
        logic              wr;
        logic [TIME_W-1:0] data;
    } efsd_cmd_t;

endpackage
`default_nettype wire

// ===== hw/rtl/efsd_cell.sv =====
// one server cell: holds a finish time and merges it into the passing scan token
`default_nettype none
module efsd_cell #(
    parameter int NUM_SERVERS = efsd_pkg::NUM_SERVERS_DEF,
    parameter int IDX         = 0
) (
    input  wire                                     aclk,
    input  wire                                     aresetn,
    input  wire logic [efsd_pkg::ACT_W-1:0]         active_servers,
    input  wire efsd_pkg::efsd_cmd_t                cmd,
    input  wire logic [((NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1)-1:0] wr_idx,
    input  wire efsd_pkg::efsd_tok_t                tok_in,
    input  wire logic [((NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1)-1:0] best_i_in,
    input  wire logic [((NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1)-1:0] run_i_in,
    output efsd_pkg::efsd_tok_t                     tok_out,
    output logic [((NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1)-1:0]      best_i_out,
    output logic [((NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1)-1:0]      run_i_out
);
    import efsd_pkg::*;

    localparam int IW = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
    localparam int CW = (IW > ACT_W) ? IW : ACT_W;
    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic [TIME_W-1:0] time_reg;
    efsd_tok_t         tok_reg, tok_next;
    logic [IW-1:0]     best_i_reg, best_i_next;
    logic [IW-1:0]     run_i_reg, run_i_next;
    logic              active;

    // server 0 always takes part, so a zero count acts as one
    assign active = (IDX == 0) || (CW'(IDX) < CW'(active_servers));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_reg <= '0;
        end else if (cmd.clr) begin
            time_reg <= '0;
        end else if (cmd.wr && (wr_idx == MY_IDX)) begin
            time_reg <= cmd.data;
        end
    end

    // strict compares keep the lowest index on ties, cells are scanned in order
    always_comb begin
        tok_next    = tok_in;
        best_i_next = best_i_in;
        run_i_next  = run_i_in;
        if (IDX == 0) begin
            tok_next.best_t = time_reg;
            tok_next.run_v  = 1'b0;
            best_i_next     = MY_IDX;
        end else if (active) begin
            if (time_reg < tok_in.best_t) begin
                tok_next.run_v  = 1'b1;
                tok_next.run_t  = tok_in.best_t;
                run_i_next      = best_i_in;
                tok_next.best_t = time_reg;
                best_i_next     = MY_IDX;
            end else if (!tok_in.run_v || (time_reg < tok_in.run_t)) begin
                tok_next.run_v = 1'b1;
                tok_next.run_t = time_reg;
                run_i_next     = MY_IDX;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.v <= 1'b0;
        end else begin
            tok_reg.v <= tok_next.v;
        end
        tok_reg.run_v  <= tok_next.run_v;
        tok_reg.best_t <= tok_next.best_t;
        tok_reg.run_t  <= tok_next.run_t;
        best_i_reg     <= best_i_next;
        run_i_reg      <= run_i_next;
    end

    assign tok_out    = tok_reg;
    assign best_i_out = best_i_reg;
    assign run_i_out  = run_i_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/earliest_free_server_dispatch.sv =====
// top level: earliest-free server dispatch over a row of server cells
//
//  channel   dir   handshake             payload
//  s_        in    s_tvalid / s_tready   s_tuser = op, s_tdata = duration
//  m_        out   m_tvalid / m_tready   m_tdata = assigned, next free server
//  cfg_      in    cfg_wr_en             cfg_wr_data = active_servers
//
//  for an assign item the scan token walks the cell row one cell per cycle,
//  then the scan outcome is captured, the chosen cell is written and the
//  result is loaded; for a clear item all cells clear at acceptance, then the
//  result loads
//  synchronous active-low reset zeroes every finish time, sets the count to 64
//  a result waiting on m_tready does not stop the next item's scan, only its
//  result load
`default_nettype none
module earliest_free_server_dispatch #(
    parameter int NUM_SERVERS = efsd_pkg::NUM_SERVERS_DEF
) (
    input  wire         aclk,
    input  wire         aresetn,
    // configuration: active_servers
    input  wire         cfg_wr_en,
    input  wire [6:0]   cfg_wr_data,
    // input items
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire [15:0]  s_tdata,    // [15:0] duration
    input  wire [0:0]   s_tuser,    // [0] op
    // result items
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [15:0] m_tdata     // [5:0] assigned_server, [11:6] next_free_server
);
    import efsd_pkg::*;

    localparam int IW = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;

    // configuration register
    logic [ACT_W-1:0] act_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg <= ACTIVE_RESET;
        end else if (cfg_wr_en) begin
            act_reg <= cfg_wr_data;
        end
    end

    // cell row wiring: position k feeds cell k, position NUM_SERVERS is the end
    efsd_tok_t     tok   [NUM_SERVERS+1];
    logic [IW-1:0] bidx  [NUM_SERVERS+1];
    logic [IW-1:0] ridx  [NUM_SERVERS+1];
    logic [NUM_SERVERS-1:0] tok_live;

    efsd_cmd_t     cmd;
    logic [IW-1:0] wr_idx;
    logic          start;

    // seed token: only the valid bit matters, cell 0 fills the rest
    always_comb begin
        tok[0]       = '0;
        tok[0].v     = start;
        bidx[0]      = '0;
        ridx[0]      = '0;
    end

    for (genvar k = 0; k < NUM_SERVERS; k++) begin : g_cell
        efsd_cell #(
            .NUM_SERVERS (NUM_SERVERS),
            .IDX         (k)
        ) u_cell (
            .aclk           (aclk),
            .aresetn        (aresetn),
            .active_servers (act_reg),
            .cmd            (cmd),
            .wr_idx         (wr_idx),
            .tok_in         (tok[k]),
            .best_i_in      (bidx[k]),
            .run_i_in       (ridx[k]),
            .tok_out        (tok[k+1]),
            .best_i_out     (bidx[k+1]),
            .run_i_out      (ridx[k+1])
        );
        assign tok_live[k] = tok[k+1].v;
    end

    // scan outcome captured at the end of the row
    efsd_state_t       state_reg, state_next;
    logic [TIME_W-1:0] best_t_reg, run_t_reg;
    logic [IW-1:0]     best_i_reg, run_i_reg;
    logic              run_v_reg;
    logic [DUR_W-1:0]  dur_reg;

    // pending result and output register
    logic [IW-1:0]     pend_asg_reg, pend_asg_next;
    logic [IW-1:0]     pend_nxt_reg, pend_nxt_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [OUT_IDX_W-1:0] m_asg_reg, m_nxt_reg;
    logic              load_out;

    // saturating update of the chosen server
    logic [TIME_W:0]   sum;
    logic [TIME_W-1:0] new_t;
    logic              take_run;

    assign sum   = {1'b0, best_t_reg} + (TIME_W+1)'(dur_reg);
    assign new_t = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];

    // next free is the lesser of the runner-up and the updated server
    assign take_run = run_v_reg &&
                      ((run_t_reg < new_t) || ((run_t_reg == new_t) && (run_i_reg < best_i_reg)));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        s_tready      = 1'b0;
        start         = 1'b0;
        cmd           = '0;
        cmd.data      = new_t;
        wr_idx        = best_i_reg;
        pend_asg_next = pend_asg_reg;
        pend_nxt_next = pend_nxt_reg;
        load_out      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_tuser[0] == OP_CLEAR) begin
                        cmd.clr       = 1'b1;
                        pend_asg_next = '0;
                        pend_nxt_next = '0;
                        state_next    = ST_WAIT;
                    end else begin
                        start      = 1'b1;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (tok[NUM_SERVERS].v) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                cmd.wr        = 1'b1;
                pend_asg_next = best_i_reg;
                pend_nxt_next = take_run ? run_i_reg : best_i_reg;
                state_next    = ST_WAIT;
            end
            ST_WAIT: begin
                // hand over once the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            dur_reg <= s_tdata;
        end
        if (tok[NUM_SERVERS].v) begin
            best_t_reg <= tok[NUM_SERVERS].best_t;
            run_t_reg  <= tok[NUM_SERVERS].run_t;
            run_v_reg  <= tok[NUM_SERVERS].run_v;
            best_i_reg <= bidx[NUM_SERVERS];
            run_i_reg  <= ridx[NUM_SERVERS];
        end
        pend_asg_reg <= pend_asg_next;
        pend_nxt_reg <= pend_nxt_next;
    end

    // indices narrowed to the 6-bit result fields
    logic [IW+OUT_IDX_W-1:0] asg_ext, nxt_ext;
    assign asg_ext = {{OUT_IDX_W{1'b0}}, pend_asg_reg};
    assign nxt_ext = {{OUT_IDX_W{1'b0}}, pend_nxt_reg};

    assign m_tvalid_next = load_out ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        if (load_out) begin
            m_asg_reg <= asg_ext[OUT_IDX_W-1:0];
            m_nxt_reg <= nxt_ext[OUT_IDX_W-1:0];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, m_nxt_reg, m_asg_reg};

    // checks
    a_one_token: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(tok_live))
        else $error("more than one scan token in the cell row");

    a_token_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        tok[NUM_SERVERS].v |-> (state_reg == ST_SCAN))
        else $error("scan token reached the end outside a scan");

    a_no_clr_wr: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.clr && cmd.wr))
        else $error("cell clear and cell write in the same cycle");

    a_update_then_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPDATE) |=> (state_reg == ST_WAIT))
        else $error("update not followed by result hand-over");

endmodule
`default_nettype wire
